[src/dbsb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbsb_pkg
// shared widths, operation codes and parameter defaults of the summing bus
// ----------------------------------------------------------------------------
package dbsb_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 18;
  localparam int SUM_W    = 27;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int LENREG_W = 9;

  localparam int DEF_SLOTS     = 8;
  localparam int DEF_CHANNELS  = 2;
  localparam int DEF_BLOCK_LEN = 256;

  localparam logic [LENREG_W-1:0] LEN_RESET = LENREG_W'(256);

  localparam logic [2:0] OP_ACQUIRE = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_ARRIVE  = 3'd5;

endpackage
`default_nettype wire

[src/double_buffered_summing_bus.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_buffered_summing_bus
// mixing bus: member slots, two sample pages per channel, page flip barrier
// ----------------------------------------------------------------------------
// channel   handshake              payload
// command   start / busy           operation slot channel channels_in_use
//                                  sample_index sample_in gain last_in_block
// result    done (one-cycle beat)  sum_out granted_slot grant_ok
//                                  page_flipped current_write_page
// config    cfg_valid / cfg_ready  cfg_data (block_length)
//
// release, arrive and idle codes finish without going busy, a new beat may follow at once
// write: multiply, then store; with last_in_block the sweep then zeroes the tail,
//   BLOCK_LEN-1-sample_index entries
// clear: zeroes one channel of the write page; acquire: both pages of n channels
// read: one memory read per slot through the single read port
// rst is synchronous; the store is not cleared, acquire zeroes it per slot
// the result receiver cannot stall; done is high for exactly one cycle
// ----------------------------------------------------------------------------
module double_buffered_summing_bus #(
  parameter int SLOTS     = dbsb_pkg::DEF_SLOTS,
  parameter int CHANNELS  = dbsb_pkg::DEF_CHANNELS,
  parameter int BLOCK_LEN = dbsb_pkg::DEF_BLOCK_LEN
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  input  wire        [2:0]                      operation,
  input  wire        [2:0]                      slot,
  input  wire                                   channel,
  input  wire        [1:0]                      channels_in_use,
  input  wire        [7:0]                      sample_index,
  input  wire signed [dbsb_pkg::SAMPLE_W-1:0]   sample_in,
  input  wire signed [dbsb_pkg::GAIN_W-1:0]     gain,
  input  wire                                   last_in_block,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire        [dbsb_pkg::LENREG_W-1:0]   cfg_data,
  output logic                                  done,
  output logic signed [dbsb_pkg::SUM_W-1:0]     sum_out,
  output logic       [2:0]                      granted_slot,
  output logic                                  grant_ok,
  output logic                                  page_flipped,
  output logic                                  current_write_page
);
  import dbsb_pkg::*;

  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BW     = $clog2(BLOCK_LEN);
  localparam int ADDR_W = SW + 1 + CW + BW;
  localparam int CNT_W  = $clog2(SLOTS + 1) + 1;
  localparam int ACC_W  = SAMPLE_W + $clog2(SLOTS) + 1;
  localparam int EL_W   = (BW + 1 > LENREG_W) ? BW + 1 : LENREG_W;

  typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_WRITE, S_READ, S_SUM} state_t;

  state_t state;

  // member bookkeeping
  logic [SLOTS-1:0] active, counted, arrived;
  logic [CNT_W-1:0] member_count, arrival_count;
  logic             wps;
  logic [LENREG_W-1:0] block_length;

  // captured command
  logic [SW-1:0] slot_r;
  logic [CW-1:0] ch_r;
  logic [BW-1:0] idx_r;
  logic          idx_ok_r;
  logic          last_r;

  // zeroing sweep
  logic [SW-1:0] sw_slot;
  logic          sw_page, sw_pg_last;
  logic [CW-1:0] sw_ch, sw_ch_last;
  logic [BW-1:0] sw_idx;

  // read accumulation
  logic [SW:0]              rd_cnt;
  logic                     rd_pend;
  logic signed [ACC_W-1:0]  acc;
  logic signed [31:0]       acc_ext;

  // memory port
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
  logic signed [SAMPLE_W-1:0]  mem_wdata, mem_rdata, scaled;

  logic accept;
  logic slot_ok, ch_ok, idx_ok;
  logic [SW-1:0] slot_ix;
  logic [SLOTS-1:0] slot_bit;
  logic [EL_W-1:0] eff_len;
  logic [1:0] nch_c;
  logic        next_in_block;

  logic          free_found;
  logic [SW-1:0] free_ix;

  // arrive next state
  logic             arv_en, arv_stalled, arv_flip;
  logic [SLOTS-1:0] arv_counted, arv_arrived;
  logic [CNT_W-1:0] arv_mc, arv_ac;
  logic [CNT_W-1:0] arv_drop;

  assign busy               = (state != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign accept             = start && !busy;
  assign current_write_page = wps;

  assign slot_ok  = (32'(slot) < SLOTS);
  assign ch_ok    = (32'(channel) < CHANNELS);
  assign slot_ix  = SW'(slot);
  assign slot_bit = SLOTS'(1) << slot_ix;

  // effective block length, clamped to 1..BLOCK_LEN
  always_comb begin
    if (block_length == '0) begin
      eff_len = EL_W'(1);
    end else if (32'(block_length) > BLOCK_LEN) begin
      eff_len = EL_W'(BLOCK_LEN);
    end else begin
      eff_len = EL_W'(block_length);
    end
  end

  assign idx_ok        = (EL_W'(sample_index) < eff_len);
  // tail zeroing uses the captured index, the command ports may already move on
  assign next_in_block = ((32'(idx_r) + 32'd1) < BLOCK_LEN);
  assign nch_c         = (32'(channels_in_use) > CHANNELS) ? 2'(CHANNELS) : channels_in_use;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_ix    = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_ix    = SW'(i);
      end
    end
  end

  // barrier update for an arrive beat
  always_comb begin
    arv_en      = slot_ok && active[slot_ix];
    arv_stalled = arrived[slot_ix];
    arv_counted = counted | slot_bit;
    arv_arrived = arrived | slot_bit;
    arv_mc      = member_count + CNT_W'(!counted[slot_ix]);
    arv_ac      = arrival_count + CNT_W'(1);
    arv_flip    = (arv_ac >= arv_mc) || arv_stalled;
    arv_drop    = '0;
    if (arv_flip) begin
      if (arv_stalled) begin
        // members that missed the round stop being counted
        for (int i = 0; i < SLOTS; i++) begin
          if (active[i] && arv_counted[i] && !arv_arrived[i]) begin
            arv_counted[i] = 1'b0;
            arv_drop       = arv_drop + CNT_W'(1);
          end
        end
        arv_arrived = slot_bit;
        arv_ac      = CNT_W'(1);
      end else begin
        arv_arrived = '0;
        arv_ac      = '0;
      end
      arv_mc = arv_mc - arv_drop;
    end
  end

  // memory port: sweep zeroes, write stores the scaled sample, read walks slots
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {slot_r, wps, ch_r, idx_r};
    mem_wdata = scaled;
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = {sw_slot, sw_page, sw_ch, sw_idx};
      mem_wdata = '0;
    end else if (state == S_WRITE) begin
      mem_we = idx_ok_r;
    end
  end

  assign mem_raddr = {rd_cnt[SW-1:0], ~wps, ch_r, idx_r};
  assign acc_ext   = 32'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active        <= '0;
      counted       <= '0;
      arrived       <= '0;
      member_count  <= '0;
      arrival_count <= '0;
      wps           <= 1'b0;
      block_length  <= LEN_RESET;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        block_length <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sum_out      <= '0;
            granted_slot <= '0;
            grant_ok     <= 1'b0;
            page_flipped <= 1'b0;
            slot_r       <= slot_ix;
            ch_r         <= CW'(channel);
            idx_r        <= BW'(sample_index);
            idx_ok_r     <= idx_ok;
            last_r       <= last_in_block;
            priority case (operation)
              OP_ACQUIRE: begin
                if (free_found) begin
                  active[free_ix]  <= 1'b1;
                  counted[free_ix] <= 1'b1;
                  arrived[free_ix] <= 1'b0;
                  member_count     <= member_count + CNT_W'(1);
                  granted_slot     <= 3'(free_ix);
                  grant_ok         <= 1'b1;
                  if (nch_c != 2'd0) begin
                    sw_slot    <= free_ix;
                    sw_page    <= 1'b0;
                    sw_pg_last <= 1'b1;
                    sw_ch      <= '0;
                    sw_ch_last <= CW'(nch_c - 2'd1);
                    sw_idx     <= '0;
                    state      <= S_SWEEP;
                  end else begin
                    done <= 1'b1;
                  end
                end else begin
                  done <= 1'b1;
                end
              end
              OP_RELEASE: begin
                if (slot_ok && active[slot_ix]) begin
                  active[slot_ix]  <= 1'b0;
                  counted[slot_ix] <= 1'b0;
                  arrived[slot_ix] <= 1'b0;
                  if (counted[slot_ix] && member_count != '0) begin
                    member_count <= member_count - CNT_W'(1);
                  end
                  arrival_count <= '0;
                end
                done <= 1'b1;
              end
              OP_WRITE: begin
                if (slot_ok && ch_ok) begin
                  state <= S_WRITE;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_CLEAR: begin
                if (slot_ok && ch_ok) begin
                  sw_slot    <= slot_ix;
                  sw_page    <= wps;
                  sw_pg_last <= wps;
                  sw_ch      <= CW'(channel);
                  sw_ch_last <= CW'(channel);
                  sw_idx     <= '0;
                  state      <= S_SWEEP;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_READ: begin
                if (ch_ok && idx_ok) begin
                  rd_cnt  <= '0;
                  rd_pend <= 1'b0;
                  acc     <= '0;
                  state   <= S_READ;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_ARRIVE: begin
                if (arv_en) begin
                  counted       <= arv_counted;
                  arrived       <= arv_arrived;
                  member_count  <= arv_mc;
                  arrival_count <= arv_ac;
                  page_flipped  <= arv_flip;
                  if (arv_flip) begin
                    wps <= ~wps;
                  end
                end
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_WRITE: begin
          // the scaled sample is stored this cycle if its index is in the block; optionally zero the tail
          if (last_r && next_in_block) begin
            sw_slot    <= slot_r;
            sw_page    <= wps;
            sw_pg_last <= wps;
            sw_ch      <= ch_r;
            sw_ch_last <= ch_r;
            sw_idx     <= idx_r + BW'(1);
            state      <= S_SWEEP;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (sw_idx == BW'(BLOCK_LEN - 1)) begin
            sw_idx <= '0;
            if (sw_ch == sw_ch_last) begin
              sw_ch <= '0;
              if (sw_page == sw_pg_last) begin
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                sw_page <= ~sw_page;
              end
            end else begin
              sw_ch <= sw_ch + CW'(1);
            end
          end else begin
            sw_idx <= sw_idx + BW'(1);
          end
        end
        S_READ: begin
          // issue one slot per cycle, add the previous slot's data
          if (rd_pend) begin
            acc <= acc + ACC_W'(mem_rdata);
          end
          if (32'(rd_cnt) < SLOTS) begin
            rd_pend <= active[rd_cnt[SW-1:0]];
            rd_cnt  <= rd_cnt + (SW + 1)'(1);
          end else begin
            rd_pend <= 1'b0;
            state   <= S_SUM;
          end
        end
        S_SUM: begin
          if (acc_ext > 32'sd67108863) begin
            sum_out <= SUM_W'(67108863);
          end else if (acc_ext < -32'sd67108864) begin
            sum_out <= SUM_W'(-67108864);
          end else begin
            sum_out <= SUM_W'(acc_ext);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dbsb_scale u_scale (
    .clk       (clk),
    .load      (accept),
    .sample_in (sample_in),
    .gain      (gain),
    .scaled    (scaled)
  );

  dbsb_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

[src/dbsb_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbsb_store
// sample page memory, one write and one registered read port
// ----------------------------------------------------------------------------
module dbsb_store #(
  parameter int ADDR_W = 13
) (
  input  wire                                    clk,
  input  wire                                    we,
  input  wire        [ADDR_W-1:0]                waddr,
  input  wire signed [dbsb_pkg::SAMPLE_W-1:0]    wdata,
  input  wire        [ADDR_W-1:0]                raddr,
  output logic signed [dbsb_pkg::SAMPLE_W-1:0]   rdata
);
  import dbsb_pkg::*;

  logic [SAMPLE_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/dbsb_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbsb_scale
// gain multiply, registered, then round half up and saturate to 24 bits
// ----------------------------------------------------------------------------
module dbsb_scale (
  input  wire                                   clk,
  input  wire                                   load,
  input  wire signed [dbsb_pkg::SAMPLE_W-1:0]   sample_in,
  input  wire signed [dbsb_pkg::GAIN_W-1:0]     gain,
  output logic signed [dbsb_pkg::SAMPLE_W-1:0]  scaled
);
  import dbsb_pkg::*;

  localparam int SH_W = PROD_W + 1 - 16;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   rounded;
  logic signed [SH_W-1:0]   shifted;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= sample_in * gain;
    end
  end

  always_comb begin
    rounded = (PROD_W + 1)'(prod) + (PROD_W + 1)'(32768);
    shifted = SH_W'(rounded >>> 16);
    if (shifted > SH_W'(8388607)) begin
      scaled = SAMPLE_W'(8388607);
    end else if (shifted < -SH_W'(8388608)) begin
      scaled = SAMPLE_W'(-8388608);
    end else begin
      scaled = SAMPLE_W'(shifted);
    end
  end

endmodule
`default_nettype wire

[src/dbsb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbsb_checker
// port-level checks of the summing bus, bound to the top level
// ----------------------------------------------------------------------------
module dbsb_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 start,
  input wire                                 busy,
  input wire                                 done,
  input wire signed [dbsb_pkg::SUM_W-1:0]    sum_out,
  input wire                                 grant_ok,
  input wire                                 page_flipped,
  input wire                                 current_write_page
);
  import dbsb_pkg::*;

  // a result only follows an accepted beat or a busy stretch
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) && !$past(busy)) || $past(busy))
    else $error("result without command");

  // busy starts only from an accepted beat
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without command");

  // grant results carry no sum and no flip
  a_grant_clean: assert property (@(posedge clk) disable iff (rst)
    done && grant_ok |-> !page_flipped && sum_out == '0)
    else $error("grant result mixed with other fields");

  // write page moves exactly with a flip
  a_flip_toggle: assert property (@(posedge clk) disable iff (rst)
    done && page_flipped |-> current_write_page != $past(current_write_page))
    else $error("flip without page change");

  a_page_hold: assert property (@(posedge clk) disable iff (rst)
    done && !page_flipped |-> current_write_page == $past(current_write_page))
    else $error("page change without flip");

endmodule

bind double_buffered_summing_bus dbsb_checker u_dbsb_checker (
  .clk                (clk),
  .rst                (rst),
  .start              (start),
  .busy               (busy),
  .done               (done),
  .sum_out            (sum_out),
  .grant_ok           (grant_ok),
  .page_flipped       (page_flipped),
  .current_write_page (current_write_page)
);
`default_nettype wire
